>>> rtl/spa_pkg.sv
`default_nettype none
package spa_pkg;

  // Field widths of one term
  localparam int COEF_W = 32;
  localparam int EXP_W  = 10;
  localparam int ACT_W  = 2;

  // Default list depth
  localparam int MAX_TERMS_DEF = 16;

  // Request action codes; the fourth code is unused and ignored
  localparam logic [ACT_W-1:0] ACT_LOAD_A = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_B = 2'd1;
  localparam logic [ACT_W-1:0] ACT_START  = 2'd2;

  // Merge sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_MERGE,
    S_FINISH
  } state_t;

  // Write port of one term list
  typedef struct packed {
    logic              en;
    logic [COEF_W-1:0] coefficient;
    logic [EXP_W-1:0]  exponent;
  } list_wr_t;

  // Sequencer status towards the request side
  typedef struct packed {
    logic idle;
    logic clear;
  } seq_ctl_t;

endpackage
`default_nettype wire

>>> rtl/spa_in_if.sv
`default_nettype none
interface spa_in_if
  import spa_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [COEF_W-1:0] coefficient;
  logic [EXP_W-1:0]         exponent;

  modport source (output valid, output action, output coefficient, output exponent,
                  input ready);
  modport sink (input valid, input action, input coefficient, input exponent,
                output ready);
endinterface
`default_nettype wire

>>> rtl/spa_out_if.sv
`default_nettype none
interface spa_out_if
  import spa_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] out_coefficient;
  logic [EXP_W-1:0]         out_exponent;
  logic                     last;
  logic                     empty_res;
  logic                     load_error;

  modport source (output valid, output out_coefficient, output out_exponent,
                  output last, output empty_res, output load_error, input ready);
  modport sink (input valid, input out_coefficient, input out_exponent,
                input last, input empty_res, input load_error, output ready);
endinterface
`default_nettype wire

>>> rtl/spa_term_list.sv
`default_nettype none
module spa_term_list
  import spa_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int CNT_W = $clog2(MAX_TERMS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire list_wr_t          wr,
  input  wire logic              clr,
  input  wire logic [IDX_W-1:0]  rd_idx,
  output logic [COEF_W-1:0]      rd_coef,
  output logic [EXP_W-1:0]       rd_exp,
  output logic [CNT_W-1:0]       count,
  output logic                   drop
);

  logic [COEF_W-1:0] coef_mem [MAX_TERMS];
  logic [EXP_W-1:0]  exp_mem  [MAX_TERMS];
  logic [EXP_W-1:0]  last_exp;
  logic              room;
  logic              in_order;
  logic              take;

  // Append check: list not full and exponent strictly descending
  always_comb begin
    room     = (count < CNT_W'(MAX_TERMS));
    in_order = (count == '0) || (wr.exponent < last_exp);
    take     = wr.en && room && in_order;
    drop     = wr.en && !take;
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clr) begin
      count <= '0;
    end else if (take) begin
      count <= count + 1'b1;
    end
  end

  // Term storage, registered read
  always_ff @(posedge clk) begin
    if (take) begin
      coef_mem[count[IDX_W-1:0]] <= wr.coefficient;
      exp_mem[count[IDX_W-1:0]]  <= wr.exponent;
      last_exp                   <= wr.exponent;
    end
    rd_coef <= coef_mem[rd_idx];
    rd_exp  <= exp_mem[rd_idx];
  end

endmodule
`default_nettype wire

>>> rtl/spa_merge_seq.sv
`default_nettype none
module spa_merge_seq
  import spa_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int CNT_W = $clog2(MAX_TERMS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              error_flag,
  input  wire logic [CNT_W-1:0]  a_count,
  input  wire logic [CNT_W-1:0]  b_count,
  input  wire logic [COEF_W-1:0] a_coef,
  input  wire logic [EXP_W-1:0]  a_exp,
  input  wire logic [COEF_W-1:0] b_coef,
  input  wire logic [EXP_W-1:0]  b_exp,
  output logic [IDX_W-1:0]       a_idx,
  output logic [IDX_W-1:0]       b_idx,
  output seq_ctl_t               ctl,
  spa_out_if.source              out_ch
);

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  i;
  logic [CNT_W-1:0]  j;

  // Held term: emitted only once the next one (or the end) is known
  logic              hold_valid;
  logic [COEF_W-1:0] hold_coef;
  logic [EXP_W-1:0]  hold_exp;

  // Output register
  logic              out_valid;
  logic [COEF_W-1:0] out_coef;
  logic [EXP_W-1:0]  out_exp;
  logic              out_last;
  logic              out_empty;
  logic              out_err;

  logic              a_left;
  logic              b_left;
  logic              a_gt;
  logic              b_gt;
  logic              take_a;
  logic              take_b;
  logic              take_both;
  logic [COEF_W:0]   sum_wide;
  logic [COEF_W-1:0] sum_sat;
  logic [COEF_W-1:0] new_coef;
  logic [EXP_W-1:0]  new_exp;
  logic              new_valid;
  logic              out_free;
  logic              adv;
  logic              fin;

  // Shared compare and saturating add
  always_comb begin
    a_left    = (i < a_count);
    b_left    = (j < b_count);
    a_gt      = (a_exp > b_exp);
    b_gt      = (b_exp > a_exp);
    take_a    = !b_left || (a_left && a_gt);
    take_b    = !take_a && (!a_left || b_gt);
    take_both = !take_a && !take_b;
    sum_wide  = {a_coef[COEF_W-1], a_coef} + {b_coef[COEF_W-1], b_coef};
    if (sum_wide[COEF_W] != sum_wide[COEF_W-1]) begin
      sum_sat = sum_wide[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}}
                                 : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[COEF_W-1:0];
    end
    if (take_a) begin
      new_coef = a_coef;
      new_exp  = a_exp;
    end else if (take_b) begin
      new_coef = b_coef;
      new_exp  = b_exp;
    end else begin
      new_coef = sum_sat;
      new_exp  = a_exp;
    end
    new_valid = !take_both || (sum_sat != '0);
  end

  // Step enables
  always_comb begin
    out_free = !out_valid || out_ch.ready;
    adv      = (state == S_MERGE) && (!(new_valid && hold_valid) || out_free);
    fin      = (state == S_FINISH) && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_FETCH;
      end
      S_FETCH: begin
        if (!a_left && !b_left) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        if (adv) state_next = S_FETCH;
      end
      S_FINISH: begin
        if (fin) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    a_idx                  = i[IDX_W-1:0];
    b_idx                  = j[IDX_W-1:0];
    ctl.idle               = (state == S_IDLE);
    ctl.clear              = fin;
    out_ch.valid           = out_valid;
    out_ch.out_coefficient = out_coef;
    out_ch.out_exponent    = out_exp;
    out_ch.last            = out_last;
    out_ch.empty_res       = out_empty;
    out_ch.load_error      = out_err;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      i          <= '0;
      j          <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (start && state == S_IDLE) begin
        i          <= '0;
        j          <= '0;
        hold_valid <= 1'b0;
      end else if (adv) begin
        if (take_a || take_both) i <= i + 1'b1;
        if (take_b || take_both) j <= j + 1'b1;
        if (new_valid) hold_valid <= 1'b1;
      end else if (fin) begin
        hold_valid <= 1'b0;
      end
      if (fin || (adv && new_valid && hold_valid)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Term payload registers
  always_ff @(posedge clk) begin
    if (adv && new_valid) begin
      hold_coef <= new_coef;
      hold_exp  <= new_exp;
    end
    if (fin) begin
      out_coef  <= hold_valid ? hold_coef : '0;
      out_exp   <= hold_valid ? hold_exp : '0;
      out_last  <= 1'b1;
      out_empty <= !hold_valid;
      out_err   <= error_flag;
    end else if (adv && new_valid && hold_valid) begin
      out_coef  <= hold_coef;
      out_exp   <= hold_exp;
      out_last  <= 1'b0;
      out_empty <= 1'b0;
      out_err   <= error_flag;
    end
  end

  // Merge pointers never run past the loaded terms
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (i <= a_count && j <= b_count))
    else $error("merge pointer beyond list fill");

  // An empty sum is always the final item
  empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> out_last)
    else $error("empty result not marked last");

  // Finishing clears both lists and returns to idle
  finish_clears: assert property (@(posedge clk) disable iff (rst)
    fin |=> (state == S_IDLE && a_count == '0 && b_count == '0))
    else $error("lists not cleared after merge");

  // A new result is only loaded into a free output register
  no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> (out_valid && $stable(out_coef)))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> rtl/sparse_polynomial_add.sv
// Sparse polynomial adder.
// Channel "items" carries requests: action 0 appends a term to list A, action 1
// to list B, action 2 starts the merge; action 3 is ignored. Each list holds up
// to MAX_TERMS terms in strictly descending exponent order; a load that is out
// of order or hits a full list is dropped and sets a sticky error flag.
// Channel "results" carries the sum terms in descending exponent order, with
// last on the final one. An empty sum gives a single item with empty_res set.
// Every result of a merge carries the error flag, which is then cleared along
// with both lists.
// Sequence: loads are taken back to back while idle. A merge step passes
// through S_FETCH (memory read) and S_MERGE (compare/add in the shared unit)
// over at most a_count + b_count steps, then S_FINISH; the registered term
// memories call for S_FETCH. Results appear one item behind the merge.
// No request is taken while a merge runs. A stalled receiver holds the output
// register and the merge waits on it. Reset empties both lists and clears the
// error flag; term storage is not cleared.
`default_nettype none
module sparse_polynomial_add
  import spa_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int CNT_W = $clog2(MAX_TERMS + 1)
) (
  input  wire logic clk,
  input  wire logic rst,
  spa_in_if.sink    items,
  spa_out_if.source results
);

  list_wr_t          a_wr;
  list_wr_t          b_wr;
  logic              a_drop;
  logic              b_drop;
  logic [CNT_W-1:0]  a_count;
  logic [CNT_W-1:0]  b_count;
  logic [IDX_W-1:0]  a_idx;
  logic [IDX_W-1:0]  b_idx;
  logic [COEF_W-1:0] a_coef;
  logic [EXP_W-1:0]  a_exp;
  logic [COEF_W-1:0] b_coef;
  logic [EXP_W-1:0]  b_exp;
  seq_ctl_t          ctl;
  logic              req_take;
  logic              start;
  logic              error_sticky;

  // Request decode
  always_comb begin
    items.ready      = ctl.idle;
    req_take         = items.valid && ctl.idle;
    a_wr.en          = req_take && (items.action == ACT_LOAD_A);
    a_wr.coefficient = items.coefficient;
    a_wr.exponent    = items.exponent;
    b_wr.en          = req_take && (items.action == ACT_LOAD_B);
    b_wr.coefficient = items.coefficient;
    b_wr.exponent    = items.exponent;
    start            = req_take && (items.action == ACT_START);
  end

  // Dropped-load flag, cleared at the end of each merge
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sticky <= 1'b0;
    end else if (ctl.clear) begin
      error_sticky <= 1'b0;
    end else if (a_drop || b_drop) begin
      error_sticky <= 1'b1;
    end
  end

  spa_term_list #(.MAX_TERMS(MAX_TERMS)) u_list_a (
    .clk     (clk),
    .rst     (rst),
    .wr      (a_wr),
    .clr     (ctl.clear),
    .rd_idx  (a_idx),
    .rd_coef (a_coef),
    .rd_exp  (a_exp),
    .count   (a_count),
    .drop    (a_drop)
  );

  spa_term_list #(.MAX_TERMS(MAX_TERMS)) u_list_b (
    .clk     (clk),
    .rst     (rst),
    .wr      (b_wr),
    .clr     (ctl.clear),
    .rd_idx  (b_idx),
    .rd_coef (b_coef),
    .rd_exp  (b_exp),
    .count   (b_count),
    .drop    (b_drop)
  );

  spa_merge_seq #(.MAX_TERMS(MAX_TERMS)) u_merge (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .error_flag (error_sticky),
    .a_count    (a_count),
    .b_count    (b_count),
    .a_coef     (a_coef),
    .a_exp      (a_exp),
    .b_coef     (b_coef),
    .b_exp      (b_exp),
    .a_idx      (a_idx),
    .b_idx      (b_idx),
    .ctl        (ctl),
    .out_ch     (results)
  );

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
  import spa_pkg::*;

  localparam int LIST_DEPTH = MAX_TERMS_DEF;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;

  // One request as offered to the block
  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [COEF_W-1:0] coefficient;
    logic [EXP_W-1:0]         exponent;
  } req_t;

  // One term of the sum as expected back
  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic [EXP_W-1:0]         exponent;
    logic                     last;
    logic                     empty_res;
    logic                     load_error;
  } term_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic clk;
  logic rst = 1'b1;

  spa_in_if  req_if ();
  spa_out_if sum_if ();

  sparse_polynomial_add #(.MAX_TERMS(LIST_DEPTH)) u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (req_if),
    .results (sum_if)
  );

  // Stimulus and expected sums
  req_t  request_q[$];
  term_t sum_terms_q[$];

  // Shadow copy of both term lists
  logic signed [COEF_W-1:0] a_coef[LIST_DEPTH];
  logic [EXP_W-1:0]         a_exp[LIST_DEPTH];
  logic signed [COEF_W-1:0] b_coef[LIST_DEPTH];
  logic [EXP_W-1:0]         b_exp[LIST_DEPTH];
  int                       a_cnt = 0;
  int                       b_cnt = 0;
  logic                     drop_seen = 1'b0;

  int requests_planned = 0;
  int requests_sent = 0;
  int merges_done = 0;
  int loads_dropped = 0;
  int sums_saturated = 0;
  int sums_cancelled = 0;
  int terms_checked = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;

  int       burst_left = 0;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_STEADY;
  int       rx_mode_left = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------

  function automatic logic signed [COEF_W-1:0] add_q16(input logic signed [COEF_W-1:0] x,
                                                       input logic signed [COEF_W-1:0] y);
    longint s;
    s = x;
    s += y;
    if (s > longint'(32'sh7FFF_FFFF)) begin
      sums_saturated++;
      return 32'sh7FFF_FFFF;
    end
    if (s < -longint'(64'h8000_0000)) begin
      sums_saturated++;
      return 32'h8000_0000;
    end
    return s[COEF_W-1:0];
  endfunction

  function automatic void push_term(input logic signed [COEF_W-1:0] coef,
                                    input logic [EXP_W-1:0] expo, input logic empty);
    term_t t;
    t.coefficient = coef;
    t.exponent    = expo;
    t.last        = 1'b0;
    t.empty_res   = empty;
    t.load_error  = drop_seen;
    sum_terms_q.push_back(t);
  endfunction

  // Sorted merge of both lists, descending exponent
  function automatic void merge_lists();
    int i;
    int j;
    int emitted;
    logic signed [COEF_W-1:0] s;
    i = 0;
    j = 0;
    emitted = 0;
    while (i < a_cnt || j < b_cnt) begin
      if (j >= b_cnt || (i < a_cnt && a_exp[i] > b_exp[j])) begin
        push_term(a_coef[i], a_exp[i], 1'b0);
        emitted++;
        i++;
      end else if (i >= a_cnt || b_exp[j] > a_exp[i]) begin
        push_term(b_coef[j], b_exp[j], 1'b0);
        emitted++;
        j++;
      end else begin
        s = add_q16(a_coef[i], b_coef[j]);
        if (s != 0) begin
          push_term(s, a_exp[i], 1'b0);
          emitted++;
        end else begin
          sums_cancelled++;
        end
        i++;
        j++;
      end
    end
    if (emitted == 0) push_term('0, '0, 1'b1);
    sum_terms_q[sum_terms_q.size()-1].last = 1'b1;
    a_cnt = 0;
    b_cnt = 0;
    drop_seen = 1'b0;
    merges_done++;
  endfunction

  // Update the shadow lists for one accepted request
  function automatic void apply_request(input req_t r);
    case (r.action)
      ACT_LOAD_A: begin
        if (a_cnt >= LIST_DEPTH || (a_cnt > 0 && r.exponent >= a_exp[a_cnt-1])) begin
          drop_seen = 1'b1;
          loads_dropped++;
        end else begin
          a_coef[a_cnt] = r.coefficient;
          a_exp[a_cnt]  = r.exponent;
          a_cnt++;
        end
      end
      ACT_LOAD_B: begin
        if (b_cnt >= LIST_DEPTH || (b_cnt > 0 && r.exponent >= b_exp[b_cnt-1])) begin
          drop_seen = 1'b1;
          loads_dropped++;
        end else begin
          b_coef[b_cnt] = r.coefficient;
          b_exp[b_cnt]  = r.exponent;
          b_cnt++;
        end
      end
      ACT_START: merge_lists();
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------

  function automatic void push_req(input req_t r);
    request_q.push_back(r);
    if (r.action != ACT_UNUSED) requests_planned++;
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    int v;
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: begin
        v = $urandom_range(0, 511);
        v -= 256;
        return v * 65536;
      end
      default: return $urandom();
    endcase
  endfunction

  // One pair of polynomials: shared descending exponents tagged A, B or both
  function automatic void build_sequence(input bit fill_a);
    int n_exp;
    int lo;
    int hi;
    int e;
    int prev;
    int pick;
    req_t a_q[$];
    req_t b_q[$];
    logic signed [COEF_W-1:0] ca;
    logic signed [COEF_W-1:0] cb;
    if (fill_a) n_exp = LIST_DEPTH + 2;
    else if ($urandom_range(0, 9) == 0) n_exp = $urandom_range(12, 34);
    else n_exp = $urandom_range(0, 6);
    prev = 1 << EXP_W;
    for (int k = 0; k < n_exp; k++) begin
      lo = n_exp - 1 - k;
      hi = prev - 1;
      if ($urandom_range(0, 1) == 0) begin
        e = $urandom_range(hi, lo);
      end else begin
        e = hi - $urandom_range(0, 3);
        if (e < lo) e = lo;
      end
      prev = e;
      pick = fill_a ? 0 : $urandom_range(0, 2);
      ca = rand_coef();
      cb = rand_coef();
      // matching exponents: bias towards cancellation and overflow
      if (pick == 2) begin
        case ($urandom_range(0, 5))
          0, 1: cb = -ca;
          2: begin
            ca = {2'b01, 30'($urandom())};
            cb = {2'b01, 30'($urandom())};
          end
          3: begin
            ca = {2'b10, 30'($urandom())};
            cb = {2'b10, 30'($urandom())};
          end
          default: ;
        endcase
      end
      if (pick != 1) a_q.push_back(req_t'{ACT_LOAD_A, ca, EXP_W'(e)});
      if (pick != 0) b_q.push_back(req_t'{ACT_LOAD_B, cb, EXP_W'(e)});
    end
    // interleave both lists, with the odd stray request
    while (a_q.size() + b_q.size() > 0) begin
      if ($urandom_range(0, 11) == 0)
        push_req(req_t'{ACT_W'($urandom_range(0, (1 << ACT_W) - 1)), $urandom(),
                        EXP_W'($urandom_range(0, (1 << EXP_W) - 1))});
      if (b_q.size() == 0 || (a_q.size() > 0 && $urandom_range(0, 1) == 0))
        push_req(a_q.pop_front());
      else
        push_req(b_q.pop_front());
    end
    push_req(req_t'{ACT_START, $urandom(), EXP_W'($urandom())});
  endfunction

  // ---------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      req_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      offer = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        apply_request(request_q[0]);
        void'(request_q.pop_front());
        requests_sent++;
        offer = 1'b0;
      end
      // bursts of random length, random gaps between them
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
      req_if.valid <= offer;
      if (offer) begin
        req_if.action      <= request_q[0].action;
        req_if.coefficient <= request_q[0].coefficient;
        req_if.exponent    <= request_q[0].exponent;
      end
    end
  end

  // ---------------------------------------------------------------
  // Result monitor and receiver stalls
  // ---------------------------------------------------------------

  function automatic void check_field(input string name, input logic [COEF_W-1:0] want,
                                      input logic [COEF_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    term_t want;
    logic  take;
    if (rst) begin
      sum_if.ready <= 1'b0;
    end else begin
      if (sum_if.valid && sum_if.ready) begin
        if (sum_terms_q.size() == 0) begin
          $error("unexpected sum term: coefficient %0h exponent %0d",
                 sum_if.out_coefficient, sum_if.out_exponent);
          fail_cnt++;
        end else begin
          want = sum_terms_q.pop_front();
          check_field("out_coefficient", want.coefficient, sum_if.out_coefficient);
          check_field("out_exponent", want.exponent, sum_if.out_exponent);
          check_field("last", want.last, sum_if.last);
          check_field("empty_res", want.empty_res, sum_if.empty_res);
          check_field("load_error", want.load_error, sum_if.load_error);
        end
        terms_checked++;
      end
      // stall pattern changes every so often
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 150);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_STEADY: take = 1'b1;
        RX_COIN:   take = $urandom_range(0, 1);
        RX_SPARSE: take = ($urandom_range(0, 3) == 0);
        default:   take = ($urandom_range(0, 7) != 0);
      endcase
      sum_if.ready <= take && (hold_left == 0);
    end
  end

  // One long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && terms_checked >= 20) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d sum terms outstanding",
               cycle_cnt, sum_terms_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    req_if.valid       = 1'b0;
    req_if.action      = ACT_LOAD_A;
    req_if.coefficient = '0;
    req_if.exponent    = '0;
    sum_if.ready       = 1'b0;

    // empty sum
    push_req(req_t'{ACT_START, '0, '0});
    // saturation both ways, lone zero coefficient, lone B term
    push_req(req_t'{ACT_LOAD_A, 32'sh7FFF_FFFF, 10'd1023});
    push_req(req_t'{ACT_LOAD_B, 32'sh7FFF_FFFF, 10'd1023});
    push_req(req_t'{ACT_LOAD_B, 32'sh0001_8000, 10'd513});
    push_req(req_t'{ACT_LOAD_A, '0, 10'd512});
    push_req(req_t'{ACT_LOAD_A, 32'h8000_0000, 10'd0});
    push_req(req_t'{ACT_LOAD_B, 32'h8000_0000, 10'd0});
    push_req(req_t'{ACT_START, '0, '0});
    // cancelling pair, out of order loads, unused action
    push_req(req_t'{ACT_LOAD_A, 32'sd327680, 10'd10});
    push_req(req_t'{ACT_LOAD_B, -32'sd327680, 10'd10});
    push_req(req_t'{ACT_LOAD_A, 32'sd65536, 10'd10});
    push_req(req_t'{ACT_LOAD_B, 32'sd65536, 10'd11});
    push_req(req_t'{ACT_UNUSED, 32'hFFFF_FFFF, 10'd1023});
    push_req(req_t'{ACT_START, '0, '0});
    // error flag cleared by the previous merge
    push_req(req_t'{ACT_LOAD_A, 32'hFFFF_FFFF, 10'd1});
    push_req(req_t'{ACT_LOAD_B, 32'sd1, 10'd1});
    push_req(req_t'{ACT_LOAD_A, 32'sd3, 10'd0});
    push_req(req_t'{ACT_START, 32'hFFFF_FFFF, 10'd1023});

    // random pairs, the first one overfilling list A
    build_sequence(1'b1);
    while (requests_planned < ITEM_TARGET) build_sequence(1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0) @(posedge clk);
    while (sum_terms_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests, %0d merges, %0d sum terms checked in %0d cycles",
             requests_sent, merges_done, terms_checked, cycle_cnt);
    $display("%0d dropped loads, %0d saturated sums, %0d cancelled terms",
             loads_dropped, sums_saturated, sums_cancelled);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
